FILE: rtl/tmtw_pkg.sv
// shared constants and types for the text mode terminal writer
package tmtw_pkg;

  localparam int unsigned COLUMNS_DEF = 80;
  localparam int unsigned ROWS_DEF    = 25;

  localparam int unsigned REQ_W   = 2;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned ATTR_W  = 8;
  localparam int unsigned CELL_W  = ATTR_W + CHAR_W;
  localparam int unsigned COL_W   = 7;
  localparam int unsigned ROW_W   = 5;
  localparam int unsigned POS_W   = 11;
  localparam int unsigned APB_AW  = 3;
  localparam int unsigned APB_DW  = 32;

  localparam int unsigned TAB_STEP = 8;

  localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

  localparam logic REG_TEXT_COLOR = 1'b0;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

endpackage

FILE: rtl/tmtw_req_if.sv
// request channel: valid, ready and one request
interface tmtw_req_if;
  import tmtw_pkg::*;

  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [CHAR_W-1:0] in_char;
  logic [COL_W-1:0]  target_col;
  logic [ROW_W-1:0]  target_row;

  modport source (output valid, req_type, in_char, target_col, target_row, input ready);
  modport sink   (input valid, req_type, in_char, target_col, target_row, output ready);
endinterface

FILE: rtl/tmtw_rsp_if.sv
// response channel: valid, ready and one result
interface tmtw_rsp_if;
  import tmtw_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_col;
  logic [ROW_W-1:0]  cursor_row;
  logic [POS_W-1:0]  cursor_pos;
  logic [CELL_W-1:0] cell_value;
  logic              scrolled;

  modport source (output valid, cursor_col, cursor_row, cursor_pos, cell_value, scrolled,
                  input ready);
  modport sink   (input valid, cursor_col, cursor_row, cursor_pos, cell_value, scrolled,
                  output ready);
endinterface

FILE: rtl/tmtw_ram.sv
// generic simple dual port ram with registered read
module tmtw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: rtl/tmtw_apb_regs.sv
// apb configuration register: text colour attribute
module tmtw_apb_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmtw_pkg::APB_AW-1:0]         paddr,
  input  logic [tmtw_pkg::APB_DW-1:0]         pwdata,
  output logic [tmtw_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  output logic [tmtw_pkg::ATTR_W-1:0]         text_color_o
);
  import tmtw_pkg::*;

  logic [ATTR_W-1:0] color_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TEXT_COLOR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ATTR_RESET;
    end else if (wr_en) begin
      color_q <= pwdata[ATTR_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TEXT_COLOR) begin
      prdata = {{(APB_DW-ATTR_W){1'b0}}, color_q};
    end
  end

  assign text_color_o = color_q;

endmodule

FILE: rtl/tmtw_ctrl.sv
// request sequencer: cursor, cell store sweeps and result register
module tmtw_ctrl #(
  parameter int unsigned COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmtw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [tmtw_pkg::ATTR_W-1:0] text_color_i,
  tmtw_req_if.sink                    req_i,
  tmtw_rsp_if.source                  rsp_o
);
  import tmtw_pkg::*;

  localparam int unsigned N  = COLUMNS * ROWS;
  localparam int unsigned AW = $clog2(N);
  localparam int unsigned CW = $clog2(COLUMNS + TAB_STEP + 1);
  localparam int unsigned RW = $clog2(ROWS + 1);
  localparam int unsigned KW = $clog2(N + COLUMNS + 1);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_EXEC   = 4'd2;
  localparam logic [3:0] S_TAB    = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_PUT    = 4'd5;
  localparam logic [3:0] S_FILL   = 4'd6;
  localparam logic [3:0] S_RDWAIT = 4'd7;
  localparam logic [3:0] S_RESP   = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [CW-1:0]     col_q, col_d;
  logic [RW-1:0]     row_q, row_d;
  logic [KW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     stop_q, stop_d;
  logic              scr_q, scr_d;
  logic [CELL_W-1:0] cell_q, cell_d;
  logic [CELL_W-1:0] fill_q, fill_d;
  logic              out_valid_q;

  logic [REQ_W-1:0]  req_q;
  logic [CHAR_W-1:0] ch_q;
  logic [COL_W-1:0]  tc_q;
  logic [ROW_W-1:0]  tr_q;

  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [CELL_W-1:0] out_cell_q;
  logic              out_scr_q;

  logic              accept;
  logic              load;
  logic [31:0]       lin;
  logic [31:0]       rd_col;
  logic [31:0]       rd_row;
  logic [31:0]       rd_lin;
  logic [31:0]       scr_raddr;
  logic [31:0]       scr_waddr;
  logic [CELL_W-1:0] blank_cell;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  tmtw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (N)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign accept      = req_i.valid && (state_q == S_IDLE);

  assign lin        = 32'(row_q) * COLUMNS + 32'(col_q);
  assign rd_col     = (32'(tc_q) > COLUMNS - 1) ? COLUMNS - 1 : 32'(tc_q);
  assign rd_row     = (32'(tr_q) > ROWS - 1) ? ROWS - 1 : 32'(tr_q);
  assign rd_lin     = rd_row * COLUMNS + rd_col;
  assign scr_raddr  = 32'(cnt_q) + COLUMNS;
  assign scr_waddr  = 32'(cnt_q) - 32'd1;
  assign blank_cell = {text_color_i, CH_BLANK};

  always_comb begin
    state_d   = state_q;
    col_d     = col_q;
    row_d     = row_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    scr_d     = scr_q;
    cell_d    = cell_q;
    fill_d    = fill_q;
    load      = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = {ATTR_RESET, CH_BLANK};
        cnt_d     = cnt_q + KW'(1);
        if (32'(cnt_q) == N - 1) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        scr_d   = 1'b0;
        cell_d  = '0;
        state_d = S_RESP;
        case (req_e'(req_q))
          REQ_PUT: begin
            case (ch_q)
              CH_NL: begin
                col_d = '0;
                if (32'(row_q) + 1 >= ROWS) begin
                  scr_d   = 1'b1;
                  cnt_d   = '0;
                  state_d = S_SCROLL;
                end else begin
                  row_d = row_q + RW'(1);
                end
              end
              CH_CR: begin
                col_d = '0;
              end
              CH_TAB: begin
                if (32'(col_q) < COLUMNS) begin
                  stop_d  = CW'((32'(col_q) + TAB_STEP) & ~(TAB_STEP - 1));
                  state_d = S_TAB;
                end
              end
              CH_BS: begin
                if (col_q != '0) begin
                  col_d     = col_q - CW'(1);
                  mem_we    = 1'b1;
                  mem_waddr = AW'(lin - 32'd1);
                  mem_wdata = blank_cell;
                end
              end
              default: begin
                state_d = S_PUT;
                if (32'(col_q) >= COLUMNS) begin
                  col_d = '0;
                  if (32'(row_q) + 1 >= ROWS) begin
                    scr_d   = 1'b1;
                    cnt_d   = '0;
                    state_d = S_SCROLL;
                  end else begin
                    row_d = row_q + RW'(1);
                  end
                end
              end
            endcase
          end
          REQ_SET: begin
            col_d = (32'(tc_q) > COLUMNS) ? CW'(COLUMNS) : CW'(tc_q);
            row_d = (32'(tr_q) > ROWS - 1) ? RW'(ROWS - 1) : RW'(tr_q);
          end
          REQ_CLEAR: begin
            col_d   = '0;
            row_d   = '0;
            cnt_d   = '0;
            fill_d  = blank_cell;
            state_d = S_FILL;
          end
          REQ_READ: begin
            mem_re    = 1'b1;
            mem_raddr = AW'(rd_lin);
            state_d   = S_RDWAIT;
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end
      S_TAB: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(lin);
        mem_wdata = blank_cell;
        col_d     = col_q + CW'(1);
        if ((32'(col_q) + 1 >= 32'(stop_q)) || (32'(col_q) + 1 >= COLUMNS)) begin
          state_d = S_RESP;
        end
      end
      S_SCROLL: begin
        // read one row ahead, write back the row above in the next cycle
        if (32'(cnt_q) < N - COLUMNS) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(scr_raddr);
        end
        if (cnt_q != '0) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(scr_waddr);
          mem_wdata = (scr_waddr < N - COLUMNS) ? mem_rdata : blank_cell;
        end
        cnt_d = cnt_q + KW'(1);
        if (32'(cnt_q) == N) begin
          cnt_d   = '0;
          state_d = (ch_q == CH_NL) ? S_RESP : S_PUT;
        end
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(lin);
        mem_wdata = {text_color_i, ch_q};
        col_d     = col_q + CW'(1);
        state_d   = S_RESP;
      end
      S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_q);
        mem_wdata = fill_q;
        cnt_d     = cnt_q + KW'(1);
        if (32'(cnt_q) == N - 1) begin
          cnt_d   = '0;
          state_d = S_RESP;
        end
      end
      S_RDWAIT: begin
        cell_d  = mem_rdata;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || rsp_o.ready) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      col_q       <= '0;
      row_q       <= '0;
      cnt_q       <= '0;
      scr_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      cnt_q   <= cnt_d;
      scr_q   <= scr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    stop_q <= stop_d;
    cell_q <= cell_d;
    fill_q <= fill_d;
    if (accept) begin
      req_q <= req_i.req_type;
      ch_q  <= req_i.in_char;
      tc_q  <= req_i.target_col;
      tr_q  <= req_i.target_row;
    end
    if (load) begin
      out_col_q  <= COL_W'(col_q);
      out_row_q  <= ROW_W'(row_q);
      out_pos_q  <= POS_W'(lin);
      out_cell_q <= cell_q;
      out_scr_q  <= scr_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.cursor_col = out_col_q;
  assign rsp_o.cursor_row = out_row_q;
  assign rsp_o.cursor_pos = out_pos_q;
  assign rsp_o.cell_value = out_cell_q;
  assign rsp_o.scrolled   = out_scr_q;

endmodule

FILE: rtl/text_mode_terminal_writer.sv
// text mode terminal writer top level
// A ROWS x COLUMNS store of 16-bit text cells (attribute high byte, character
// low byte) held in one simple dual port RAM, plus a cursor. One request is
// taken at a time and gives one result. A tab blanks up to 8 cells. A scroll
// walks the RAM row by row through its read and write ports, and clear screen
// writes every cell. After reset a clearing pass over all ROWS*COLUMNS cells
// fills the store with blanks before the first request is taken;
// configuration writes are taken throughout. A new request is taken while
// the previous result still waits in the output register.
module text_mode_terminal_writer #(
  parameter int unsigned COLUMNS = tmtw_pkg::COLUMNS_DEF,
  parameter int unsigned ROWS    = tmtw_pkg::ROWS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tmtw_pkg::APB_AW-1:0] paddr,
  input  logic [tmtw_pkg::APB_DW-1:0] pwdata,
  output logic [tmtw_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  tmtw_req_if.sink                    req_i,
  tmtw_rsp_if.source                  rsp_o
);
  import tmtw_pkg::*;

  logic [ATTR_W-1:0] text_color;

  tmtw_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .text_color_o (text_color)
  );

  tmtw_ctrl #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_color_i (text_color),
    .req_i        (req_i),
    .rsp_o        (rsp_o)
  );

endmodule

FILE: bench/text_mode_terminal_checker.sv
// watches the request, response and register buses, models the cell store and checks every result
module text_mode_terminal_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [tmtw_pkg::APB_AW-1:0] paddr,
  input  logic [tmtw_pkg::APB_DW-1:0] pwdata,
  tmtw_req_if                         req,
  tmtw_rsp_if                         rsp,
  output int unsigned                 fail_count,
  output int unsigned                 pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int unsigned NCOL = COLUMNS_DEF;
  localparam int unsigned NROW = ROWS_DEF;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
  } cursor_result_t;

  logic [CELL_W-1:0] cells [NCOL*NROW];
  int unsigned       col_q;
  int unsigned       row_q;
  logic [ATTR_W-1:0] attr_q;
  cursor_result_t    expected_results [$];

  function automatic logic [CELL_W-1:0] text_cell(input logic [CHAR_W-1:0] ch);
    return {attr_q, ch};
  endfunction

  task automatic put_cell(input int unsigned r, input int unsigned c,
                          input logic [CHAR_W-1:0] ch);
    if (r < NROW && c < NCOL) begin
      cells[r*NCOL + c] = text_cell(ch);
    end
  endtask

  task automatic blank_screen();
    for (int unsigned i = 0; i < NCOL*NROW; i++) begin
      cells[i] = text_cell(CH_BLANK);
    end
  endtask

  task automatic scroll_up();
    for (int unsigned i = 0; i < (NROW-1)*NCOL; i++) begin
      cells[i] = cells[i + NCOL];
    end
    for (int unsigned c = 0; c < NCOL; c++) begin
      cells[(NROW-1)*NCOL + c] = text_cell(CH_BLANK);
    end
    row_q = NROW - 1;
  endtask

  task automatic line_feed(output logic did);
    col_q = 0;
    row_q++;
    did = 1'b0;
    if (row_q >= NROW) begin
      scroll_up();
      did = 1'b1;
    end
  endtask

  task automatic apply_request(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                               output cursor_result_t res);
    int unsigned stop;
    int unsigned rd_col;
    int unsigned rd_row;
    logic        did;
    res = '0;
    did = 1'b0;
    case (req_e'(kind))
      REQ_PUT: begin
        case (ch)
          CH_NL: line_feed(did);
          CH_CR: col_q = 0;
          CH_TAB: begin
            stop = (col_q + TAB_STEP) & ~(TAB_STEP - 1);
            while (col_q < stop && col_q < NCOL) begin
              put_cell(row_q, col_q, CH_BLANK);
              col_q++;
            end
          end
          CH_BS: begin
            if (col_q > 0) begin
              col_q--;
              put_cell(row_q, col_q, CH_BLANK);
            end
          end
          default: begin
            if (col_q >= NCOL) begin
              line_feed(did);
            end
            put_cell(row_q, col_q, ch);
            col_q++;
          end
        endcase
      end
      REQ_SET: begin
        col_q = (col > NCOL) ? NCOL : col;
        row_q = (row > NROW - 1) ? NROW - 1 : row;
      end
      REQ_CLEAR: begin
        blank_screen();
        col_q = 0;
        row_q = 0;
      end
      REQ_READ: begin
        rd_col = (col > NCOL - 1) ? NCOL - 1 : col;
        rd_row = (row > NROW - 1) ? NROW - 1 : row;
        res.cell_value = cells[rd_row*NCOL + rd_col];
      end
    endcase
    res.cursor_col = COL_W'(col_q);
    res.cursor_row = ROW_W'(row_q);
    res.cursor_pos = POS_W'(row_q*NCOL + col_q);
    res.scrolled   = did;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    cursor_result_t want;
    cursor_result_t next_want;
    if (!rst_ni) begin
      attr_q = ATTR_RESET;
      blank_screen();
      col_q = 0;
      row_q = 0;
      expected_results.delete();
      fail_count = 0;
      pending_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("response transfer with no request outstanding");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("cursor_col", want.cursor_col, rsp.cursor_col);
          check_field("cursor_row", want.cursor_row, rsp.cursor_row);
          check_field("cursor_pos", want.cursor_pos, rsp.cursor_pos);
          check_field("cell_value", want.cell_value, rsp.cell_value);
          check_field("scrolled", want.scrolled, rsp.scrolled);
        end
      end
      if (psel && penable && pwrite && pready && paddr == APB_AW'(4 * REG_TEXT_COLOR)) begin
        attr_q = pwdata[ATTR_W-1:0];
      end
      if (req.valid && req.ready) begin
        apply_request(req.req_type, req.in_char, req.target_col, req.target_row, next_want);
        expected_results.push_back(next_want);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

FILE: bench/tb_text_mode_terminal_writer.sv
// top of the terminal writer bench: clock, reset, register writes, requests and verdict
module tb_text_mode_terminal_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int unsigned CLK_PERIOD  = 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS = 325;
  localparam int unsigned NUM_PHASES  = 4;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  bit                gaps_on = 1'b1;
  bit                hold_rsp = 1'b0;
  int unsigned       fail_count;
  int unsigned       pending_count;

  tmtw_req_if req_bus ();
  tmtw_rsp_if rsp_bus ();

  text_mode_terminal_writer i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus)
  );

  text_mode_terminal_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .req           (req_bus),
    .rsp           (rsp_bus),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  task automatic write_text_color(input logic [ATTR_W-1:0] colour);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * REG_TEXT_COLOR);
    pwdata  <= APB_DW'(colour);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_req(input req_e kind, input logic [CHAR_W-1:0] ch,
                          input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(0, 99) < 25) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.req_type   <= kind;
    req_bus.in_char    <= ch;
    req_bus.target_col <= col;
    req_bus.target_row <= row;
    do @(posedge clk_i); while (!req_bus.ready);
  endtask

  task automatic drain();
    @(negedge clk_i);
    req_bus.valid <= 1'b0;
    wait (pending_count == 0);
  endtask

  task automatic send_random_req();
    int unsigned          roll;
    int unsigned          char_roll;
    logic [CHAR_W-1:0]    ch;
    logic [COL_W-1:0]     col;
    logic [ROW_W-1:0]     row;
    roll = $urandom_range(0, 99);
    col  = COL_W'($urandom_range(0, 127));
    row  = ROW_W'($urandom_range(0, 31));
    if (roll < 75) begin
      char_roll = $urandom_range(0, 99);
      if (char_roll < 80)      ch = CHAR_W'($urandom_range(32, 126));
      else if (char_roll < 84) ch = CH_NL;
      else if (char_roll < 88) ch = CH_CR;
      else if (char_roll < 92) ch = CH_TAB;
      else if (char_roll < 96) ch = CH_BS;
      else                     ch = CHAR_W'($urandom_range(0, 255));
      send_req(REQ_PUT, ch, col, row);
    end else if (roll < 83) begin
      if ($urandom_range(0, 3) == 0) begin
        col = COL_W'($urandom_range(76, 80));
      end
      send_req(REQ_SET, CHAR_W'($urandom_range(0, 255)), col, row);
    end else if (roll < 98) begin
      send_req(REQ_READ, CHAR_W'($urandom_range(0, 255)), col, row);
    end else begin
      send_req(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)), col, row);
    end
  endtask

  initial begin : rsp_ready_gen
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_rsp = 1'b0;
      end else if (gaps_on) begin
        rsp_bus.ready <= ($urandom_range(0, 99) >= 25);
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [ATTR_W-1:0] colour;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_PUT;
    req_bus.in_char    = '0;
    req_bus.target_col = '0;
    req_bus.target_row = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_req(REQ_READ, 8'h00, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'h41, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'hFF, 7'd127, 5'd31);
    send_req(REQ_PUT, 8'h00, 7'd0, 5'd0);
    send_req(REQ_PUT, CH_TAB, 7'd0, 5'd0);
    send_req(REQ_PUT, CH_BS, 7'd0, 5'd0);
    send_req(REQ_PUT, CH_CR, 7'd0, 5'd0);
    send_req(REQ_PUT, CH_NL, 7'd0, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd1, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd2, 5'd0);
    // out of range cursor, then backspace and tab with a wrap pending
    send_req(REQ_SET, 8'h00, 7'd127, 5'd31);
    send_req(REQ_PUT, CH_BS, 7'd0, 5'd0);
    send_req(REQ_SET, 8'h00, 7'd80, 5'd24);
    send_req(REQ_PUT, CH_TAB, 7'd0, 5'd0);
    send_req(REQ_PUT, 8'h78, 7'd0, 5'd0);
    send_req(REQ_SET, 8'h00, 7'd80, 5'd24);
    send_req(REQ_PUT, CH_NL, 7'd0, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd127, 5'd31);
    send_req(REQ_SET, 8'h00, 7'd0, 5'd0);
    send_req(REQ_PUT, CH_BS, 7'd0, 5'd0);
    send_req(REQ_SET, 8'h00, 7'd75, 5'd3);
    send_req(REQ_PUT, CH_TAB, 7'd0, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd79, 5'd3);
    send_req(REQ_CLEAR, 8'h00, 7'd0, 5'd0);
    send_req(REQ_READ, 8'h00, 7'd40, 5'd12);
    drain();

    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       colour = 8'hFF;
        1:       colour = 8'h00;
        2:       colour = ATTR_W'($urandom_range(0, 255));
        default: colour = 8'h5A;
      endcase
      write_text_color(colour);
      gaps_on = (phase != 2);
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == 40) begin
          hold_rsp = 1'b1;
        end
        send_random_req();
      end
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS text_mode_terminal_writer");
    end else begin
      $display("FAIL text_mode_terminal_writer");
    end
    $finish;
  end

  initial begin : watchdog
    #(200_000_000);
    $display("FAIL text_mode_terminal_writer");
    $finish;
  end

endmodule

FILE: sim.f
rtl/tmtw_pkg.sv
rtl/tmtw_req_if.sv
rtl/tmtw_rsp_if.sv
rtl/tmtw_ram.sv
rtl/tmtw_apb_regs.sv
rtl/tmtw_ctrl.sv
rtl/text_mode_terminal_writer.sv
bench/text_mode_terminal_checker.sv
bench/tb_text_mode_terminal_writer.sv
